// ===== rtl/core/mger_pkg.sv =====
// Package for the mesh greedy edge router: constants, state encoding and
// sequencer control types. No dependencies.
`timescale 1ns / 1ps
package mger_pkg;
   localparam int MAX_SIDE = 16;

   localparam int NODE_W = 8;
   localparam int SIDE_W = 5;
   localparam int LIM_W  = 8;
   localparam int HOP_W  = 5;
   localparam int CNT_W  = 16;
   localparam int USED_W = 11;

   localparam logic [1:0] DIR_XP = 2'd0;
   localparam logic [1:0] DIR_XN = 2'd1;
   localparam logic [1:0] DIR_YP = 2'd2;
   localparam logic [1:0] DIR_YN = 2'd3;

   localparam logic [1:0] REG_SIDE  = 2'd0;
   localparam logic [1:0] REG_LIMIT = 2'd1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SETUP,
      ST_DIV,
      ST_FETCH,
      ST_WAIT,
      ST_DECIDE,
      ST_ROUND,
      ST_RIP_FETCH,
      ST_RIP_WAIT,
      ST_RIP_BYP,
      ST_RIP_WR,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic       first;
      logic       phase_y;
      logic [1:0] dir;
   } step_type;
endpackage

// ===== rtl/core/mesh_greedy_edge_router.sv =====
// Mesh greedy edge router with rip-up: top level with sequencer, link and
// bypass memories and the path store. Depends on mger_pkg, mger_ram, mger_step_unit.
// Steps: setup, then for nodes in range a row split, link checks, decides and
// rounds, rip-up of each link taken on failure, and the strobe. One item in
// flight; the next is accepted in the cycle after the strobe.
// Reset clears counters, then a clearing pass frees all links and bypass
// counts; busy is high during it. No receiver stall.
`timescale 1ns / 1ps
module mesh_greedy_edge_router #(
   parameter int PATH_DEPTH = 30
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [7:0]  req_source_node,
   input  logic [7:0]  req_target_node,
   output logic        rsp_valid,
   output logic        rsp_routed,
   output logic [4:0]  rsp_hop_count,
   output logic [15:0] rsp_routed_total,
   output logic [15:0] rsp_failed_total,
   output logic [10:0] rsp_links_in_use,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   localparam int NODES = mger_pkg::MAX_SIDE * mger_pkg::MAX_SIDE;
   localparam int NW    = $clog2(NODES);
   localparam int CW    = $clog2(mger_pkg::MAX_SIDE);
   localparam int PW    = $clog2(PATH_DEPTH);
   localparam int HW    = $clog2(PATH_DEPTH + 1);

   mger_pkg::state_type state_ff, state_in;
   logic [4:0]  side_ff;
   logic [7:0]  limit_ff;
   logic [15:0] rcnt_ff, rcnt_in, fcnt_ff, fcnt_in;
   logic [10:0] used_ff, used_in;
   logic [CW-1:0] ccol_ff, ccol_in, crow_ff, crow_in, tcol_ff, tcol_in, trow_ff, trow_in;
   logic [HW-1:0] hops_ff, hops_in;
   logic [HW-1:0] rip_ff, rip_in;
   mger_pkg::step_type step_ff, step_in;
   logic        mod_ff, mod_in, ok_ff, ok_in;
   logic [NW-1:0] clr_ff, clr_in;
   logic [7:0]  src_ff, src_in, tgt_ff, tgt_in;
   logic [1:0]  rdir_ff, rdir_in;
   logic [NW-1:0] rnode_ff, rnode_in;
   logic        rbyp_ff, rbyp_in;

   // config
   logic cfg_wr;
   logic [4:0] side_eff;
   logic [5:0] side_ext;
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;
   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff  <= 5'd8;
         limit_ff <= 8'd2;
      end else if (cfg_wr) begin
         if (paddr[2] == mger_pkg::REG_LIMIT[0]) begin
            limit_ff <= pwdata[7:0];
         end else begin
            side_ff <= pwdata[4:0];
         end
      end
   end
   always_comb begin
      prdata = 32'd0;
      if (paddr[2] == mger_pkg::REG_SIDE[0]) begin
         prdata[4:0] = side_ff;
      end else begin
         prdata[7:0] = limit_ff;
      end
   end
   assign side_eff = (side_ff < 5'd2) ? 5'd2 :
                     ({1'b0, side_ff} > 6'(mger_pkg::MAX_SIDE)) ?
                     5'(mger_pkg::MAX_SIDE) : side_ff;
   assign side_ext = {1'b0, side_eff};

   // node index from coordinates (small mult by side)
   logic [NW-1:0] cur_node;
   assign cur_node = NW'(32'(crow_ff) * 32'(side_eff) + 32'(ccol_ff));

   // row split by repeated subtraction of the side
   logic [7:0] side_byte;
   logic       src_ge, tgt_ge;
   assign side_byte = {3'b000, side_eff};
   assign src_ge = (src_ff >= side_byte);
   assign tgt_ge = (tgt_ff >= side_byte);

   // step unit
   logic need_x, need_y;
   logic [1:0] dir_x, dir_y;
   mger_step_unit #(.CW(CW)) u_step (
      .cur_col(ccol_ff), .cur_row(crow_ff), .tgt_col(tcol_ff), .tgt_row(trow_ff),
      .need_x(need_x), .need_y(need_y), .dir_x(dir_x), .dir_y(dir_y)
   );

   // memories
   logic          lk_we, lk_wd, lk_rd;
   logic [NW+1:0] lk_wa, lk_ra;
   logic          bp_we;
   logic [NW-1:0] bp_wa, bp_ra;
   logic [7:0]    bp_wd, bp_rd;
   logic          pa_we;
   logic [PW-1:0] pa_wa, pa_ra;
   logic [NW+2:0] pa_wd, pa_rd;

   mger_ram #(.WIDTH(1), .DEPTH(NODES * 4)) u_link (
      .clock(clock), .wr_en(lk_we), .wr_addr(lk_wa), .wr_data(lk_wd),
      .rd_addr(lk_ra), .rd_data(lk_rd));
   mger_ram #(.WIDTH(8), .DEPTH(NODES)) u_bypass (
      .clock(clock), .wr_en(bp_we), .wr_addr(bp_wa), .wr_data(bp_wd),
      .rd_addr(bp_ra), .rd_data(bp_rd));
   mger_ram #(.WIDTH(NW + 3), .DEPTH(PATH_DEPTH)) u_path (
      .clock(clock), .wr_en(pa_we), .wr_addr(pa_wa), .wr_data(pa_wd),
      .rd_addr(pa_ra), .rd_data(pa_rd));

   logic [1:0] cdir;
   assign cdir = step_ff.dir;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mger_pkg::ST_CLEAR;
         rcnt_ff  <= '0;
         fcnt_ff  <= '0;
         used_ff  <= '0;
         clr_ff   <= '0;
         rip_ff   <= '0;
      end else begin
         state_ff <= state_in;
         rcnt_ff  <= rcnt_in;
         fcnt_ff  <= fcnt_in;
         used_ff  <= used_in;
         clr_ff   <= clr_in;
         rip_ff   <= rip_in;
      end
      ccol_ff <= ccol_in; crow_ff <= crow_in; tcol_ff <= tcol_in; trow_ff <= trow_in;
      hops_ff <= hops_in; step_ff <= step_in; mod_ff <= mod_in;
      ok_ff <= ok_in; src_ff <= src_in; tgt_ff <= tgt_in;
      rdir_ff <= rdir_in; rnode_ff <= rnode_in; rbyp_ff <= rbyp_in;
   end

   logic [8:0] ncap;
   logic in_range;
   assign ncap = 9'(side_ext * side_ext);
   assign in_range = ({1'b0, src_ff} < ncap) && ({1'b0, tgt_ff} < ncap);

   always_comb begin
      state_in = state_ff;
      rcnt_in = rcnt_ff; fcnt_in = fcnt_ff; used_in = used_ff; clr_in = clr_ff;
      ccol_in = ccol_ff; crow_in = crow_ff; tcol_in = tcol_ff; trow_in = trow_ff;
      hops_in = hops_ff; rip_in = rip_ff; step_in = step_ff; mod_in = mod_ff;
      ok_in = ok_ff; src_in = src_ff; tgt_in = tgt_ff;
      rdir_in = rdir_ff; rnode_in = rnode_ff; rbyp_in = rbyp_ff;
      lk_we = 1'b0; lk_wa = {cur_node, cdir}; lk_wd = 1'b1; lk_ra = {cur_node, cdir};
      bp_we = 1'b0; bp_wa = cur_node; bp_wd = bp_rd + 8'd1; bp_ra = cur_node;
      pa_we = 1'b0; pa_wa = PW'(hops_ff); pa_wd = {cur_node, cdir, ~step_ff.first};
      pa_ra = PW'(rip_ff);
      busy = 1'b1; rsp_valid = 1'b0;
      case (state_ff)
         mger_pkg::ST_CLEAR: begin
            lk_we = 1'b1; lk_wd = 1'b0; bp_we = 1'b1; bp_wd = 8'd0;
            bp_wa = clr_ff[NW-1:0];
            lk_wa = {clr_ff[NW-1:0], rip_ff[1:0]};
            rip_in = HW'(rip_ff[1:0] + 2'd1);
            if (rip_ff[1:0] == 2'd3) begin
               clr_in = clr_ff + 1'b1;
               if (clr_ff[NW-1:0] == NW'(NODES - 1)) begin
                  state_in = mger_pkg::ST_IDLE;
               end
            end
         end
         mger_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               src_in = req_source_node;
               tgt_in = req_target_node;
               state_in = mger_pkg::ST_SETUP;
            end
         end
         mger_pkg::ST_SETUP: begin
            ok_in = 1'b0;
            hops_in = '0;
            mod_in = 1'b0;
            step_in.first = 1'b1;
            step_in.phase_y = 1'b0;
            crow_in = '0;
            trow_in = '0;
            state_in = in_range ? mger_pkg::ST_DIV : mger_pkg::ST_DONE;
         end
         mger_pkg::ST_DIV: begin
            if (src_ge) begin
               src_in = src_ff - side_byte;
               crow_in = crow_ff + 1'b1;
            end
            if (tgt_ge) begin
               tgt_in = tgt_ff - side_byte;
               trow_in = trow_ff + 1'b1;
            end
            if (!src_ge && !tgt_ge) begin
               ccol_in = src_ff[CW-1:0];
               tcol_in = tgt_ff[CW-1:0];
               state_in = mger_pkg::ST_DECIDE;
            end
         end
         mger_pkg::ST_DECIDE: begin
            if (!step_ff.phase_y && need_x) begin
               step_in.dir = dir_x;
               state_in = (hops_ff >= HW'(PATH_DEPTH)) ? mger_pkg::ST_ROUND : mger_pkg::ST_FETCH;
               if (hops_ff >= HW'(PATH_DEPTH)) step_in.phase_y = 1'b1;
            end else if (need_y) begin
               step_in.phase_y = 1'b1;
               step_in.dir = dir_y;
               state_in = (hops_ff >= HW'(PATH_DEPTH)) ? mger_pkg::ST_ROUND : mger_pkg::ST_FETCH;
            end else begin
               state_in = mger_pkg::ST_ROUND;
            end
            if (step_ff.phase_y && hops_ff >= HW'(PATH_DEPTH)) state_in = mger_pkg::ST_ROUND;
            if (!step_ff.phase_y && need_x && hops_ff >= HW'(PATH_DEPTH)) begin
               step_in.phase_y = 1'b1;
               state_in = mger_pkg::ST_DECIDE;
            end
         end
         mger_pkg::ST_FETCH: begin
            state_in = mger_pkg::ST_WAIT;
         end
         mger_pkg::ST_WAIT: begin
            if (lk_rd || (!step_ff.first && bp_rd >= limit_ff)) begin
               if (step_ff.phase_y) begin
                  state_in = mger_pkg::ST_ROUND;
               end else begin
                  step_in.phase_y = 1'b1;
                  state_in = mger_pkg::ST_DECIDE;
               end
            end else begin
               lk_we = 1'b1;
               bp_we = !step_ff.first;
               pa_we = 1'b1;
               used_in = used_ff + 11'd1;
               hops_in = hops_ff + 1'b1;
               mod_in = 1'b1;
               step_in.first = 1'b0;
               case (cdir)
                  mger_pkg::DIR_XP: ccol_in = ccol_ff + 1'b1;
                  mger_pkg::DIR_XN: ccol_in = ccol_ff - 1'b1;
                  mger_pkg::DIR_YP: crow_in = crow_ff + 1'b1;
                  default:          crow_in = crow_ff - 1'b1;
               endcase
               state_in = mger_pkg::ST_DECIDE;
            end
         end
         mger_pkg::ST_ROUND: begin
            if (!need_x && !need_y) begin
               ok_in = 1'b1;
               if (rcnt_ff != 16'hFFFF) rcnt_in = rcnt_ff + 16'd1;
               state_in = mger_pkg::ST_DONE;
            end else if (!mod_ff) begin
               rip_in = '0;
               if (fcnt_ff != 16'hFFFF) fcnt_in = fcnt_ff + 16'd1;
               state_in = mger_pkg::ST_RIP_FETCH;
            end else begin
               mod_in = 1'b0;
               step_in.phase_y = 1'b0;
               state_in = mger_pkg::ST_DECIDE;
            end
         end
         mger_pkg::ST_RIP_FETCH: begin
            if (rip_ff == hops_ff) begin
               hops_in = '0;
               state_in = mger_pkg::ST_DONE;
            end else begin
               state_in = mger_pkg::ST_RIP_WAIT;
            end
         end
         mger_pkg::ST_RIP_WAIT: begin
            rnode_in = pa_rd[NW+2:3];
            rdir_in = pa_rd[2:1];
            rbyp_in = pa_rd[0];
            state_in = mger_pkg::ST_RIP_BYP;
         end
         mger_pkg::ST_RIP_BYP: begin
            bp_ra = rnode_ff;
            state_in = mger_pkg::ST_RIP_WR;
         end
         mger_pkg::ST_RIP_WR: begin
            lk_we = 1'b1; lk_wd = 1'b0; lk_wa = {rnode_ff, rdir_ff};
            bp_wa = rnode_ff; bp_wd = bp_rd - 8'd1;
            bp_we = rbyp_ff && (bp_rd != 8'd0);
            used_in = used_ff - 11'd1;
            rip_in = rip_ff + 1'b1;
            state_in = mger_pkg::ST_RIP_FETCH;
         end
         mger_pkg::ST_DONE: begin
            rsp_valid = 1'b1;
            state_in = mger_pkg::ST_IDLE;
         end
         default: state_in = mger_pkg::ST_IDLE;
      endcase
   end

   assign rsp_routed       = ok_ff;
   assign rsp_hop_count    = ok_ff ? 5'(hops_ff) : 5'd0;
   assign rsp_routed_total = rcnt_ff;
   assign rsp_failed_total = fcnt_ff;
   assign rsp_links_in_use = used_ff;
endmodule

// ===== rtl/core/mger_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module mger_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/core/mger_step_unit.sv =====
// Shared step unit: picks the next direction from the current node's
// coordinates and the target. Depends on mger_pkg.
`timescale 1ns / 1ps
module mger_step_unit #(
   parameter int CW = 4
) (
   input  logic [CW-1:0] cur_col,
   input  logic [CW-1:0] cur_row,
   input  logic [CW-1:0] tgt_col,
   input  logic [CW-1:0] tgt_row,
   output logic          need_x,
   output logic          need_y,
   output logic [1:0]    dir_x,
   output logic [1:0]    dir_y
);
   assign need_x = (cur_col != tgt_col);
   assign need_y = (cur_row != tgt_row);
   assign dir_x  = (tgt_col > cur_col) ? mger_pkg::DIR_XP : mger_pkg::DIR_XN;
   assign dir_y  = (tgt_row > cur_row) ? mger_pkg::DIR_YP : mger_pkg::DIR_YN;
endmodule

// ===== rtl/core/mger_checker.sv =====
// Port-level checker for the mesh greedy edge router, bound to the top level.
// Depends on mesh_greedy_edge_router ports only.
`timescale 1ns / 1ps
module mger_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic        rsp_routed,
   input logic [4:0]  rsp_hop_count,
   input logic [15:0] rsp_routed_total,
   input logic [15:0] rsp_failed_total
);
   a_fail_no_hops: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_routed |-> rsp_hop_count == 5'd0)
      else $error("failed item reports hops");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after accept");
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");
   a_failed_steady: assert property (@(posedge clock) disable iff (reset)
      !busy && !$past(reset) |-> $stable(rsp_failed_total))
      else $error("failed total moved while idle");
   a_routed_steady: assert property (@(posedge clock) disable iff (reset)
      !busy && !$past(reset) |-> $stable(rsp_routed_total))
      else $error("routed total moved while idle");
endmodule

bind mesh_greedy_edge_router mger_checker u_mger_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_routed(rsp_routed), .rsp_hop_count(rsp_hop_count),
   .rsp_routed_total(rsp_routed_total), .rsp_failed_total(rsp_failed_total));

// ===== tb/sv/tb_mesh_greedy_edge_router.sv =====
// Testbench for mesh_greedy_edge_router: directed and random edges through the command
// port, register writes over APB, and a scoreboard class that predicts every result.
// Depends on mger_pkg and the router RTL.
`timescale 1ns / 1ps
module tb_mesh_greedy_edge_router;
   import mger_pkg::*;

   localparam int PATH_DEPTH = 30;
   localparam int STALL_MAX  = 5000;

   typedef struct {
      logic              routed;
      logic [HOP_W-1:0]  hop_count;
      logic [CNT_W-1:0]  routed_total;
      logic [CNT_W-1:0]  failed_total;
      logic [USED_W-1:0] links_in_use;
   } route_result_type;

   class route_scoreboard;
      bit                link_taken [MAX_SIDE*MAX_SIDE*4];
      logic [LIM_W-1:0]  node_pass [MAX_SIDE*MAX_SIDE];
      int unsigned       trail_node [PATH_DEPTH];
      logic [1:0]        trail_dir [PATH_DEPTH];
      bit                trail_pass [PATH_DEPTH];
      int unsigned       routed_cnt, failed_cnt, links_used;
      logic [SIDE_W-1:0] side_reg;
      logic [LIM_W-1:0]  limit_reg;
      route_result_type  expected_q [$];
      int                errors;

      function new();
         foreach (link_taken[i]) link_taken[i] = 0;
         foreach (node_pass[i]) node_pass[i] = '0;
         routed_cnt = 0;
         failed_cnt = 0;
         links_used = 0;
         side_reg   = 5'd8;
         limit_reg  = 8'd2;
         errors     = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [31:0] value);
         if (idx == REG_SIDE) side_reg = value[SIDE_W-1:0];
         else if (idx == REG_LIMIT) limit_reg = value[LIM_W-1:0];
      endfunction

      function bit grab_link(int unsigned cur, logic [1:0] d, bit lead, int unsigned hops);
         int unsigned li;
         li = cur * 4 + d;
         if (hops >= PATH_DEPTH) return 0;
         if (link_taken[li]) return 0;
         if (!lead && node_pass[cur] >= limit_reg) return 0;
         link_taken[li] = 1;
         links_used++;
         if (!lead) node_pass[cur]++;
         trail_node[hops] = cur;
         trail_dir[hops]  = d;
         trail_pass[hops] = !lead;
         return 1;
      endfunction

      function void note_edge(logic [7:0] src, logic [7:0] tgt);
         int unsigned      s, n, cur, hops, tc, tr, nd;
         bit               lead, ok, moved;
         logic [1:0]       d;
         route_result_type r;
         s = 32'(side_reg);
         if (s < 2) s = 2;
         if (s > MAX_SIDE) s = MAX_SIDE;
         n = s * s;
         hops = 0;
         lead = 1;
         ok = 0;
         if (src < n && tgt < n) begin
            tc = tgt % s;
            tr = tgt / s;
            cur = src;
            forever begin
               moved = 0;
               while (cur % s != tc) begin
                  d = (tc > cur % s) ? DIR_XP : DIR_XN;
                  if (!grab_link(cur, d, lead, hops)) break;
                  cur = (d == DIR_XP) ? cur + 1 : cur - 1;
                  hops++;
                  lead = 0;
                  moved = 1;
               end
               while (cur / s != tr) begin
                  d = (tr > cur / s) ? DIR_YP : DIR_YN;
                  if (!grab_link(cur, d, lead, hops)) break;
                  cur = (d == DIR_YP) ? cur + s : cur - s;
                  hops++;
                  lead = 0;
                  moved = 1;
               end
               if (cur == tgt) begin
                  ok = 1;
                  break;
               end
               if (!moved) break;
            end
            if (ok) begin
               if (routed_cnt < 16'hFFFF) routed_cnt++;
            end else begin
               // rip up everything taken for this edge
               for (int i = 0; i < hops; i++) begin
                  nd = trail_node[i];
                  link_taken[nd * 4 + trail_dir[i]] = 0;
                  links_used--;
                  if (trail_pass[i] && node_pass[nd] > 0) node_pass[nd]--;
               end
               hops = 0;
               if (failed_cnt < 16'hFFFF) failed_cnt++;
            end
         end
         r.routed       = ok;
         r.hop_count    = hops[HOP_W-1:0];
         r.routed_total = routed_cnt[CNT_W-1:0];
         r.failed_total = failed_cnt[CNT_W-1:0];
         r.links_in_use = links_used[USED_W-1:0];
         expected_q.push_back(r);
      endfunction

      function void check_result(route_result_type got);
         route_result_type exp_r;
         if (expected_q.size() == 0) begin
            $error("result with no item outstanding");
            errors++;
            return;
         end
         exp_r = expected_q.pop_front();
         if (got.routed !== exp_r.routed) begin
            $error("routed: expected %0d actual %0d", exp_r.routed, got.routed);
            errors++;
         end
         if (got.hop_count !== exp_r.hop_count) begin
            $error("hop_count: expected %0d actual %0d", exp_r.hop_count, got.hop_count);
            errors++;
         end
         if (got.routed_total !== exp_r.routed_total) begin
            $error("routed_total: expected %0d actual %0d",
                   exp_r.routed_total, got.routed_total);
            errors++;
         end
         if (got.failed_total !== exp_r.failed_total) begin
            $error("failed_total: expected %0d actual %0d",
                   exp_r.failed_total, got.failed_total);
            errors++;
         end
         if (got.links_in_use !== exp_r.links_in_use) begin
            $error("links_in_use: expected %0d actual %0d",
                   exp_r.links_in_use, got.links_in_use);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [7:0]  req_source_node;
   logic [7:0]  req_target_node;
   logic        rsp_valid;
   logic        rsp_routed;
   logic [4:0]  rsp_hop_count;
   logic [15:0] rsp_routed_total;
   logic [15:0] rsp_failed_total;
   logic [10:0] rsp_links_in_use;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   route_scoreboard sb = new();
   int              stall_cycles = 0;

   mesh_greedy_edge_router #(
      .PATH_DEPTH(PATH_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_source_node(req_source_node),
      .req_target_node(req_target_node),
      .rsp_valid(rsp_valid),
      .rsp_routed(rsp_routed),
      .rsp_hop_count(rsp_hop_count),
      .rsp_routed_total(rsp_routed_total),
      .rsp_failed_total(rsp_failed_total),
      .rsp_links_in_use(rsp_links_in_use),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      route_result_type got;
      if (!reset && rsp_valid) begin
         got.routed       = rsp_routed;
         got.hop_count    = rsp_hop_count;
         got.routed_total = rsp_routed_total;
         got.failed_total = rsp_failed_total;
         got.links_in_use = rsp_links_in_use;
         sb.check_result(got);
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (psel && penable)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_MAX) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic write_reg(logic [1:0] idx, logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 1'b0} << 1;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      sb.write_reg(idx, value);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic send_edge(logic [7:0] src, logic [7:0] tgt, int idle_pct);
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_source_node <= src;
      req_target_node <= tgt;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      sb.note_edge(src, tgt);
   endtask

   task automatic set_mesh(logic [4:0] side, logic [7:0] lim);
      drain();
      write_reg(REG_SIDE, {27'd0, side});
      write_reg(REG_LIMIT, {24'd0, lim});
   endtask

   initial begin
      int unsigned s, n, idle_pct;
      logic [7:0]  src, tgt;
      logic [4:0]  sides [7];
      logic [7:0]  limits [7];
      sides  = '{5'd2, 5'd31, 5'd16, 5'd0, 5'd7, 5'd16, 5'd12};
      limits = '{8'd0, 8'd1, 8'd255, 8'd3, 8'd2, 8'd1, 8'd255};
      reset = 1'b1;
      start = 1'b0;
      req_source_node = '0;
      req_target_node = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_mesh(5'd4, 8'd2);
      send_edge(8'd0, 8'd15, 0);
      send_edge(8'd15, 8'd0, 0);
      send_edge(8'd5, 8'd5, 0);
      send_edge(8'd16, 8'd0, 0);
      send_edge(8'd0, 8'd255, 0);
      send_edge(8'd255, 8'd255, 0);
      send_edge(8'd3, 8'd12, 0);
      send_edge(8'd12, 8'd3, 0);
      send_edge(8'd0, 8'd15, 0);
      send_edge(8'd1, 8'd13, 0);
      set_mesh(5'd16, 8'd255);
      send_edge(8'd0, 8'd255, 0);
      send_edge(8'd255, 8'd0, 0);
      send_edge(8'd15, 8'd240, 0);
      send_edge(8'd0, 8'd255, 0);
      send_edge(8'd170, 8'd85, 0);
      set_mesh(5'd16, 8'd0);
      send_edge(8'd33, 8'd34, 0);
      send_edge(8'd20, 8'd100, 0);
      send_edge(8'd100, 8'd84, 0);
      send_edge(8'd200, 8'd200, 0);

      for (int ph = 0; ph < 7; ph++) begin
         set_mesh(sides[ph], limits[ph]);
         idle_pct = (ph < 2) ? 26 : (ph < 5) ? 51 : 0;
         s = 32'(sides[ph]);
         if (s < 2) s = 2;
         if (s > MAX_SIDE) s = MAX_SIDE;
         n = s * s;
         for (int k = 0; k < 76; k++) begin
            if ($urandom_range(99) < 88) begin
               src = 8'($urandom_range(n - 1));
               tgt = 8'($urandom_range(n - 1));
            end else begin
               src = 8'($urandom_range(255));
               tgt = 8'($urandom_range(255));
            end
            send_edge(src, tgt, idle_pct);
         end
      end

      drain();
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
